>>> rtl/ssra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssra_pkg
// Shared types, widths and codes for the stack slot region allocator.
// ----------------------------------------------------------------------------
package ssra_pkg;

  localparam int MAX_REGIONS = 32;
  localparam int LIVE_BITS   = 64;
  localparam int OFFSET_BITS = 20;
  localparam int SIZE_BITS   = 16;
  localparam int ALIGN_BITS  = 4;
  localparam int IN_LIVE_W   = 64;
  localparam int COUNT_BITS  = 6;

  // Working width of offset arithmetic: holds base + size + alignment slack.
  localparam int CALC_W = ((OFFSET_BITS > SIZE_BITS) ? OFFSET_BITS : SIZE_BITS) + 2;
  localparam int IDX_W  = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 3);
  localparam int ADDR_W = IDX_W + 1;
  localparam int ENT_W  = 2 * OFFSET_BITS + LIVE_BITS;

  localparam logic [CALC_W-1:0] OFF_MAX =
    {{(CALC_W - OFFSET_BITS){1'b0}}, {OFFSET_BITS{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN_RD,
    S_SCAN_EV,
    S_CHECK,
    S_COPY_RD,
    S_COPY_WR,
    S_APP_GAP,
    S_APP_NEW,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] rstart;
    logic [OFFSET_BITS-1:0] rend;
    logic [LIVE_BITS-1:0]   live;
  } region_t;

endpackage
`default_nettype wire

>>> rtl/ssra_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssra_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ssra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/ssra_align.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssra_align
// Shared placement unit: from a base offset, finds the start whose end is
// aligned to the object's alignment.
// ----------------------------------------------------------------------------
module ssra_align (
  input  wire logic [ssra_pkg::CALC_W-1:0]     base,
  input  wire logic [ssra_pkg::SIZE_BITS-1:0]  size,
  input  wire logic [ssra_pkg::ALIGN_BITS-1:0] align_log2,
  output logic      [ssra_pkg::CALC_W-1:0]     start_pos,
  output logic      [ssra_pkg::CALC_W-1:0]     fin_pos
);

  logic [ssra_pkg::CALC_W-1:0] amask;
  logic [ssra_pkg::CALC_W-1:0] size_x;
  logic [ssra_pkg::CALC_W-1:0] sum;

  assign amask  = ~({ssra_pkg::CALC_W{1'b1}} << align_log2);
  assign size_x = {{(ssra_pkg::CALC_W - ssra_pkg::SIZE_BITS){1'b0}}, size};
  assign sum    = base + size_x;
  // Round the end up, then step back by the size.
  assign fin_pos   = (sum + amask) & ~amask;
  assign start_pos = fin_pos - size_x;

endmodule
`default_nettype wire

>>> rtl/stack_slot_region_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_slot_region_allocator
// Places stack objects in a frame kept as an ordered table of live regions.
// ----------------------------------------------------------------------------
// Each input beat places one object and returns one result beat carrying the
// object's end offset, the region count and a status code. The region table
// lives in one RAM split into two banks; a placement reads the active bank
// and, with layout enabled, writes the rebuilt table into the other bank,
// which becomes active only when the placement succeeds. With layout
// disabled an item passes through accept, alignment, check and result.
// With layout enabled, the first-fit scan spends one RAM read and one
// evaluation on each region it visits, the rebuild takes one read per
// region and one write per region piece (at most two pieces more than
// regions), and accept, alignment, check, the two appends, commit and
// result make up the remaining steps. The RAM has a single read port and
// the block one shared alignment unit. A stalled result beat holds the
// block in its result step. The block takes no new item until the result of
// the current one has moved into the output register. The table needs no
// clearing after reset since only entries below the count are read.
// ----------------------------------------------------------------------------
module stack_slot_region_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write channel.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_layout_enabled,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_new_frame,
  input  wire logic [ssra_pkg::SIZE_BITS-1:0]    in_object_size,
  input  wire logic [ssra_pkg::ALIGN_BITS-1:0]   in_align_log2,
  input  wire logic [ssra_pkg::IN_LIVE_W-1:0]    in_live_mask,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [ssra_pkg::OFFSET_BITS-1:0]  out_end_offset,
  output logic      [ssra_pkg::COUNT_BITS-1:0]   out_region_count,
  output logic      [1:0]                        out_status
);

  localparam int CW = ssra_pkg::CALC_W;
  localparam int OB = ssra_pkg::OFFSET_BITS;
  localparam int IW = ssra_pkg::IDX_W;
  localparam int NW = ssra_pkg::CNT_W;
  localparam int LB = ssra_pkg::LIVE_BITS;

  ssra_pkg::state_t  state_r, state_nxt;
  ssra_pkg::status_t status_r;

  // Configuration and table bookkeeping.
  logic          layout_r;
  logic          bank_r;
  logic [NW-1:0] used_r;
  logic [OB-1:0] last_end_r;

  // Current item.
  logic [ssra_pkg::SIZE_BITS-1:0]  size_r;
  logic [ssra_pkg::ALIGN_BITS-1:0] alog_r;
  logic [LB-1:0]                   mask_r;
  logic [CW-1:0]                   start_r;
  logic [CW-1:0]                   end_r;

  // Sequencer counters.
  logic [NW-1:0] idx_r;
  logic [NW-1:0] wc_r;
  logic [OB-1:0] cur_lo_r;
  logic          first_r;

  // Output register.
  logic          out_valid_r;
  logic [OB-1:0] out_end_r;
  logic [ssra_pkg::COUNT_BITS-1:0] out_count_r;
  logic [1:0]    out_status_r;

  // RAM port signals.
  logic                          ram_we;
  logic [ssra_pkg::ADDR_W-1:0]   ram_waddr;
  logic [ssra_pkg::ADDR_W-1:0]   ram_raddr;
  ssra_pkg::region_t             ram_wdata;
  logic [ssra_pkg::ENT_W-1:0]    ram_rdata;
  ssra_pkg::region_t             rd_ent;

  // Shared alignment unit.
  logic [CW-1:0] unit_base;
  logic [CW-1:0] unit_start;
  logic [CW-1:0] unit_fin;

  // Datapath terms.
  logic [CW-1:0] leff_c;
  logic [CW-1:0] re_c;
  logic [CW-1:0] lo_c;
  logic [CW-1:0] cut_c;
  logic          app_c;
  logic          gap_c;
  logic          ov_c;
  logic          hit_c;
  logic          brk_c;
  logic          room_c;
  logic          idx_last_c;
  logic          out_free_c;

  assign rd_ent     = ssra_pkg::region_t'(ram_rdata);
  assign leff_c     = {{(CW - OB){1'b0}}, last_end_r};
  assign re_c       = {{(CW - OB){1'b0}}, rd_ent.rend};
  assign lo_c       = first_r ? {{(CW - OB){1'b0}}, rd_ent.rstart}
                              : {{(CW - OB){1'b0}}, cur_lo_r};
  assign app_c      = end_r > leff_c;
  assign gap_c      = start_r > leff_c;
  assign hit_c      = |(mask_r & rd_ent.live);
  // The scan stops at the first region that the candidate fits under.
  assign brk_c      = (start_r < re_c) && !hit_c && (end_r <= re_c);
  assign idx_last_c = (idx_r + NW'(1)) == used_r;
  assign room_c     = wc_r < NW'(ssra_pkg::MAX_REGIONS);
  assign out_free_c = !out_valid_r || out_ready;

  // Next cut of the current region: the object's start or end when strictly
  // inside, otherwise the region's own end.
  always_comb begin
    if (start_r > lo_c && start_r < re_c) begin
      cut_c = start_r;
    end else if (end_r > lo_c && end_r < re_c) begin
      cut_c = end_r;
    end else begin
      cut_c = re_c;
    end
  end

  assign ov_c = (start_r < cut_c) && (end_r > lo_c);

  ssra_align u_align (
    .base       (unit_base),
    .size       (size_r),
    .align_log2 (alog_r),
    .start_pos  (unit_start),
    .fin_pos    (unit_fin)
  );

  ssra_ram #(
    .WIDTH (ssra_pkg::ENT_W),
    .DEPTH (2 * ssra_pkg::MAX_REGIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssra_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ssra_pkg::S_INIT;
        end
      end
      ssra_pkg::S_INIT: begin
        if (layout_r && (used_r != '0)) begin
          state_nxt = ssra_pkg::S_SCAN_RD;
        end else begin
          state_nxt = ssra_pkg::S_CHECK;
        end
      end
      ssra_pkg::S_SCAN_RD: state_nxt = ssra_pkg::S_SCAN_EV;
      ssra_pkg::S_SCAN_EV: begin
        if (brk_c || idx_last_c) begin
          state_nxt = ssra_pkg::S_CHECK;
        end else begin
          state_nxt = ssra_pkg::S_SCAN_RD;
        end
      end
      ssra_pkg::S_CHECK: begin
        if ((end_r > ssra_pkg::OFF_MAX) || !layout_r) begin
          state_nxt = ssra_pkg::S_DONE;
        end else if (used_r != '0) begin
          state_nxt = ssra_pkg::S_COPY_RD;
        end else begin
          state_nxt = ssra_pkg::S_APP_GAP;
        end
      end
      ssra_pkg::S_COPY_RD: state_nxt = ssra_pkg::S_COPY_WR;
      ssra_pkg::S_COPY_WR: begin
        if (cut_c == re_c) begin
          state_nxt = idx_last_c ? ssra_pkg::S_APP_GAP : ssra_pkg::S_COPY_RD;
        end
      end
      ssra_pkg::S_APP_GAP: state_nxt = ssra_pkg::S_APP_NEW;
      ssra_pkg::S_APP_NEW: state_nxt = ssra_pkg::S_COMMIT;
      ssra_pkg::S_COMMIT:  state_nxt = ssra_pkg::S_DONE;
      ssra_pkg::S_DONE: begin
        if (out_free_c) begin
          state_nxt = ssra_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssra_pkg::S_IDLE;
    endcase
  end

  // Unit operand, RAM read and write ports.
  always_comb begin
    unit_base = '0;
    ram_we    = 1'b0;
    ram_waddr = {~bank_r, wc_r[IW-1:0]};
    ram_wdata = '{rstart: start_r[OB-1:0], rend: end_r[OB-1:0], live: mask_r};
    ram_raddr = {bank_r, idx_r[IW-1:0]};
    case (state_r)
      ssra_pkg::S_INIT: begin
        unit_base = layout_r ? '0 : leff_c;
      end
      ssra_pkg::S_SCAN_EV: begin
        unit_base = re_c;
      end
      ssra_pkg::S_CHECK: begin
        // Plain append goes straight into the active bank past the count.
        ram_waddr = {bank_r, used_r[IW-1:0]};
        ram_we    = !layout_r && !(end_r > ssra_pkg::OFF_MAX) &&
                    (used_r < NW'(ssra_pkg::MAX_REGIONS));
      end
      ssra_pkg::S_COPY_WR: begin
        ram_we    = room_c;
        ram_wdata = '{rstart: lo_c[OB-1:0], rend: cut_c[OB-1:0],
                      live: rd_ent.live | (ov_c ? mask_r : '0)};
      end
      ssra_pkg::S_APP_GAP: begin
        ram_we    = app_c && gap_c && room_c;
        ram_wdata = '{rstart: last_end_r, rend: start_r[OB-1:0], live: '0};
      end
      ssra_pkg::S_APP_NEW: begin
        ram_we    = app_c && room_c;
        ram_wdata = '{rstart: gap_c ? start_r[OB-1:0] : last_end_r,
                      rend: end_r[OB-1:0], live: mask_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssra_pkg::S_IDLE;
      layout_r    <= 1'b0;
      bank_r      <= 1'b0;
      used_r      <= '0;
      last_end_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        layout_r <= cfg_layout_enabled;
      end
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ssra_pkg::S_IDLE: begin
          if (in_valid) begin
            size_r <= in_object_size;
            alog_r <= in_align_log2;
            mask_r <= in_live_mask[LB-1:0];
            if (in_new_frame) begin
              used_r     <= '0;
              last_end_r <= '0;
            end
          end
        end
        ssra_pkg::S_INIT: begin
          start_r  <= unit_start;
          end_r    <= unit_fin;
          idx_r    <= '0;
          status_r <= ssra_pkg::ST_OK;
        end
        ssra_pkg::S_SCAN_EV: begin
          // Bump past a region whose liveness collides with the object.
          if ((start_r < re_c) && hit_c) begin
            start_r <= unit_start;
            end_r   <= unit_fin;
          end
          idx_r <= idx_r + NW'(1);
        end
        ssra_pkg::S_CHECK: begin
          wc_r  <= '0;
          idx_r <= '0;
          if (end_r > ssra_pkg::OFF_MAX) begin
            status_r <= ssra_pkg::ST_OVF;
          end else if (!layout_r) begin
            if (used_r >= NW'(ssra_pkg::MAX_REGIONS)) begin
              status_r <= ssra_pkg::ST_FULL;
            end else begin
              used_r     <= used_r + NW'(1);
              last_end_r <= end_r[OB-1:0];
            end
          end
        end
        ssra_pkg::S_COPY_RD: begin
          first_r <= 1'b1;
        end
        ssra_pkg::S_COPY_WR: begin
          first_r  <= 1'b0;
          cur_lo_r <= cut_c[OB-1:0];
          wc_r     <= wc_r + NW'(1);
          if (cut_c == re_c) begin
            idx_r <= idx_r + NW'(1);
          end
        end
        ssra_pkg::S_APP_GAP: begin
          if (app_c && gap_c) begin
            wc_r <= wc_r + NW'(1);
          end
        end
        ssra_pkg::S_APP_NEW: begin
          if (app_c) begin
            wc_r <= wc_r + NW'(1);
          end
        end
        ssra_pkg::S_COMMIT: begin
          if (wc_r > NW'(ssra_pkg::MAX_REGIONS)) begin
            status_r <= ssra_pkg::ST_FULL;
          end else begin
            bank_r <= ~bank_r;
            used_r <= wc_r;
            if (app_c) begin
              last_end_r <= end_r[OB-1:0];
            end
          end
        end
        ssra_pkg::S_DONE: begin
          if (out_free_c) begin
            out_valid_r  <= 1'b1;
            out_end_r    <= (status_r == ssra_pkg::ST_OK) ? end_r[OB-1:0] : '0;
            out_count_r  <= ssra_pkg::COUNT_BITS'(used_r);
            out_status_r <= status_r;
          end
        end
        default: begin
          first_r <= 1'b0;
        end
      endcase
    end
  end

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == ssra_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_end_offset   = out_end_r;
  assign out_region_count = out_count_r;
  assign out_status       = out_status_r;

endmodule
`default_nettype wire

>>> rtl/ssra_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssra_chk
// Port-level checks for the stack slot region allocator, bound to the top.
// ----------------------------------------------------------------------------
module ssra_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             in_new_frame,
  input wire logic [ssra_pkg::SIZE_BITS-1:0]   in_object_size,
  input wire logic [ssra_pkg::ALIGN_BITS-1:0]  in_align_log2,
  input wire logic [ssra_pkg::IN_LIVE_W-1:0]   in_live_mask,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [ssra_pkg::OFFSET_BITS-1:0] out_end_offset,
  input wire logic [ssra_pkg::COUNT_BITS-1:0]  out_region_count,
  input wire logic [1:0]                       out_status
);

  // One item at a time: right after an accepted beat the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a placement was running");

  // A waiting input beat keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_new_frame) &&
    $stable(in_object_size) && $stable(in_align_log2) && $stable(in_live_mask))
    else $error("input beat changed while waiting");

  // A failed placement reports a zero end offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ssra_pkg::ST_OK) |-> out_end_offset == '0)
    else $error("failed placement with nonzero end offset");

  // The table never holds more regions than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region_count <= ssra_pkg::COUNT_BITS'(ssra_pkg::MAX_REGIONS))
    else $error("region count beyond table size");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_end_offset) &&
    $stable(out_status) && $stable(out_region_count))
    else $error("result beat changed while stalled");

endmodule

bind stack_slot_region_allocator ssra_chk u_ssra_chk (.*);
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack slot region allocator.
// ----------------------------------------------------------------------------
// A queue of pending objects feeds a clocked driver. A clocked monitor
// checks every result beat against a bench predictor of the region table.
// The run alternates the two layout settings, with random stalls on both
// sides except in the last phase. One long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCR = ssra_pkg::MAX_REGIONS + 4;
  localparam longint unsigned OFF_LIMIT = (64'd1 << ssra_pkg::OFFSET_BITS) - 1;

  typedef bit [63:0] u64;

  typedef struct {
    bit                            new_frame;
    bit [ssra_pkg::SIZE_BITS-1:0]  size;
    bit [ssra_pkg::ALIGN_BITS-1:0] align;
    bit [ssra_pkg::IN_LIVE_W-1:0]  live;
  } obj_t;

  typedef struct {
    bit [ssra_pkg::OFFSET_BITS-1:0] end_offset;
    bit [ssra_pkg::COUNT_BITS-1:0]  region_count;
    ssra_pkg::status_t              status;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_layout_enabled = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             in_new_frame = 1'b0;
  logic [ssra_pkg::SIZE_BITS-1:0]   in_object_size = '0;
  logic [ssra_pkg::ALIGN_BITS-1:0]  in_align_log2 = '0;
  logic [ssra_pkg::IN_LIVE_W-1:0]   in_live_mask = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [ssra_pkg::OFFSET_BITS-1:0] out_end_offset;
  logic [ssra_pkg::COUNT_BITS-1:0]  out_region_count;
  logic [1:0]                       out_status;

  stack_slot_region_allocator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_layout_enabled (cfg_layout_enabled),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_new_frame       (in_new_frame),
    .in_object_size     (in_object_size),
    .in_align_log2      (in_align_log2),
    .in_live_mask       (in_live_mask),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_end_offset     (out_end_offset),
    .out_region_count   (out_region_count),
    .out_status         (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is held once, at the start.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Predictor: a shadow copy of the region table and of the layout register.
  // --------------------------------------------------------------------------
  u64 tbl_start [ssra_pkg::MAX_REGIONS];
  u64 tbl_end   [ssra_pkg::MAX_REGIONS];
  u64 tbl_live  [ssra_pkg::MAX_REGIONS];
  int tbl_used = 0;
  bit layout_on = 1'b0;

  // Working copy of the table while one object is being placed. It has a
  // few spare entries so that an oversized result can be seen and rejected.
  u64 wk_start [SCR];
  u64 wk_end   [SCR];
  u64 wk_live  [SCR];
  int wk_count;

  // Returns the start at which an object of this size ends on an aligned
  // offset, at or after the given base.
  function automatic u64 aligned_start(u64 base, u64 size, u64 align);
    u64 e;
    e = base + size;
    e = (e + align - 1) & ~(align - 1);
    return e - size;
  endfunction

  function automatic void wk_add(u64 s, u64 e, u64 m);
    if (wk_count < SCR) begin
      wk_start[wk_count] = s;
      wk_end[wk_count]   = e;
      wk_live[wk_count]  = m;
      wk_count++;
    end
  endfunction

  // Splitting a region starts by duplicating it in place.
  function automatic void wk_split(int i);
    if (wk_count >= SCR || i >= wk_count) return;
    for (int k = wk_count; k > i; k--) begin
      wk_start[k] = wk_start[k-1];
      wk_end[k]   = wk_end[k-1];
      wk_live[k]  = wk_live[k-1];
    end
    wk_count++;
  endfunction

  function automatic placement_t place_object(obj_t o);
    u64 size, align, mask, st, en, last;
    ssra_pkg::status_t stt;
    placement_t r;
    size  = u64'(o.size);
    align = u64'(1) << o.align;
    mask  = u64'(o.live);
    stt   = ssra_pkg::ST_OK;
    st    = 0;
    en    = 0;
    // A new frame clears the table even if the placement then fails.
    if (o.new_frame) tbl_used = 0;
    wk_count = tbl_used;
    for (int i = 0; i < tbl_used; i++) begin
      wk_start[i] = tbl_start[i];
      wk_end[i]   = tbl_end[i];
      wk_live[i]  = tbl_live[i];
    end
    last = (wk_count != 0) ? wk_end[wk_count-1] : 0;
    if (!layout_on) begin
      st = aligned_start(last, size, align);
      en = st + size;
      if (en > OFF_LIMIT) stt = ssra_pkg::ST_OVF;
      else wk_add(st, en, mask);
    end else begin
      // First fit: step past every region whose lifetime clashes.
      st = aligned_start(0, size, align);
      en = st + size;
      for (int i = 0; i < wk_count; i++) begin
        if (st >= wk_end[i]) continue;
        if ((mask & wk_live[i]) != 0) begin
          st = aligned_start(wk_end[i], size, align);
          en = st + size;
          continue;
        end
        if (en <= wk_end[i]) break;
      end
      if (en > OFF_LIMIT) begin
        stt = ssra_pkg::ST_OVF;
      end else begin
        if (en > last) begin
          if (st > last) begin
            wk_add(last, st, 0);
            last = st;
          end
          wk_add(last, en, mask);
        end
        // Cut regions at the object's start and end.
        for (int i = 0; i < wk_count; i++) begin
          if (st > wk_start[i] && st < wk_end[i]) begin
            wk_split(i);
            wk_end[i] = st;
            wk_start[i+1] = st;
            continue;
          end
          if (en > wk_start[i] && en < wk_end[i]) begin
            wk_split(i);
            wk_end[i] = en;
            wk_start[i+1] = en;
            break;
          end
        end
        // Mark the object live in every region it covers.
        for (int i = 0; i < wk_count; i++) begin
          if (st < wk_end[i] && en > wk_start[i]) wk_live[i] |= mask;
          if (en <= wk_end[i]) break;
        end
      end
    end
    if (stt == ssra_pkg::ST_OK && wk_count > ssra_pkg::MAX_REGIONS) stt = ssra_pkg::ST_FULL;
    if (stt == ssra_pkg::ST_OK) begin
      tbl_used = wk_count;
      for (int i = 0; i < wk_count; i++) begin
        tbl_start[i] = wk_start[i];
        tbl_end[i]   = wk_end[i];
        tbl_live[i]  = wk_live[i];
      end
      r.end_offset = en[ssra_pkg::OFFSET_BITS-1:0];
    end else begin
      r.end_offset = '0;
    end
    r.region_count = tbl_used[ssra_pkg::COUNT_BITS-1:0];
    r.status = stt;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pending objects go out one beat at a time, with random gaps.
  // --------------------------------------------------------------------------
  obj_t       pending_q[$];
  placement_t placement_q[$];
  obj_t       on_wire;
  obj_t       nxt;
  bit         calm = 1'b0;
  int         send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      // The predictor runs on the edge at which the beat is taken.
      if (in_valid && in_ready) placement_q = {placement_q, place_object(on_wire)};
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          on_wire = nxt;
          in_valid       <= 1'b1;
          in_new_frame   <= nxt.new_frame;
          in_object_size <= nxt.size;
          in_align_log2  <= nxt.align;
          in_live_mask   <= nxt.live;
          if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here so that the monitor only reads it.
  // --------------------------------------------------------------------------
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction.
  // --------------------------------------------------------------------------
  int errors = 0;
  int recv_gap = 0;
  int n_ok = 0;
  int n_full = 0;
  int n_ovf = 0;
  placement_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          $error("result beat with no object outstanding");
          errors++;
        end else begin
          want = placement_q.pop_front();
          if (out_end_offset !== want.end_offset) begin
            $error("end_offset: expected %0d, got %0d", want.end_offset, out_end_offset);
            errors++;
          end
          if (out_region_count !== want.region_count) begin
            $error("region_count: expected %0d, got %0d", want.region_count,
                   out_region_count);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          case (want.status)
            ssra_pkg::ST_OK:   n_ok++;
            ssra_pkg::ST_FULL: n_full++;
            default:           n_ovf++;
          endcase
        end
      end
      if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap  <= $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  int frame_len = 0;
  int frame_target = 4;

  function automatic obj_t mk(bit nf, int sz, int al, u64 m);
    obj_t o;
    o.new_frame = nf;
    o.size      = sz[ssra_pkg::SIZE_BITS-1:0];
    o.align     = al[ssra_pkg::ALIGN_BITS-1:0];
    o.live      = m;
    return o;
  endfunction

  // Adds one object at the back of the pending queue.
  function automatic void queue_obj(obj_t o);
    pending_q = {pending_q, o};
  endfunction

  // One lifetime in three is a short interval of program points so that reuse
  // happens; as many are full random masks, which exercise every bit.
  function automatic u64 rand_live();
    int lo, len;
    case ($urandom_range(0, 5))
      0, 1:    return {$urandom, $urandom};
      2:       return u64'(1) << $urandom_range(0, 63);
      3:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: begin
        lo  = $urandom_range(0, 63);
        len = $urandom_range(1, 12);
        return ((u64'(1) << len) - 1) << lo;
      end
    endcase
  endfunction

  // Frames are mostly short; now and then a long one fills the table.
  task automatic queue_random(int count);
    int sz, al, pick;
    bit nf;
    for (int n = 0; n < count; n++) begin
      nf = 1'b0;
      if (frame_len >= frame_target) begin
        nf = 1'b1;
        frame_len = 0;
        frame_target = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 45)
                                                  : $urandom_range(1, 12);
      end
      frame_len++;
      pick = $urandom_range(0, 99);
      if (pick < 70)      sz = $urandom_range(1, 64);
      else if (pick < 90) sz = $urandom_range(65, 4096);
      else if (pick < 95) sz = 0;
      else                sz = $urandom_range(4097, 65535);
      al = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 15);
      queue_obj(mk(nf, sz, al, rand_live()));
    end
  endtask

  // The layout register is only written while the block is idle.
  task automatic write_layout(bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_layout_enabled <= v;
    do @(posedge clk); while (!cfg_ready);
    layout_on = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || placement_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    repeat (3) @(posedge clk);

    // Plain append: empty object, largest size, widest alignments, and a
    // run of large objects that brings the frame close to its offset limit.
    write_layout(1'b0);
    queue_obj(mk(1, 0, 0, '0));
    queue_obj(mk(0, 65535, 0, '1));
    queue_obj(mk(0, 1, 15, 64'h8000_0000_0000_0001));
    queue_obj(mk(0, 3, 12, 64'h5555_5555_5555_5555));
    for (int k = 0; k < 14; k++) queue_obj(mk(0, 65535, 4, 64'hAAAA));
    drain();

    // Liveness layout: clashing and disjoint lifetimes, reuse inside an
    // existing region, and a gap before an aligned object.
    write_layout(1'b1);
    queue_obj(mk(1, 16, 2, 64'h0000_0000_0000_000F));
    queue_obj(mk(0, 8, 3, 64'h0000_0000_0000_00F0));
    queue_obj(mk(0, 32, 0, 64'h0000_0000_0000_0003));
    queue_obj(mk(0, 4, 2, 64'hFFFF_0000_0000_0000));
    queue_obj(mk(0, 0, 0, '0));
    queue_obj(mk(0, 100, 9, '1));
    queue_obj(mk(0, 65535, 15, '1));
    queue_obj(mk(1, 65535, 15, 64'h1));
    queue_obj(mk(0, 65535, 15, 64'h1));
    drain();

    // Random objects with the receiver stalled for a long stretch at first.
    queue_random(400);
    hold_go = 1'b1;
    drain();

    write_layout(1'b0);
    queue_random(300);
    drain();

    // Closing stretch with no idling on either side.
    write_layout(1'b1);
    calm = 1'b1;
    queue_random(450);
    drain();

    $display("Placed %0d objects, %0d rejected on a full table, %0d on offset overflow.",
             n_ok, n_full, n_ovf);
    $display("Layout toggled across phases, with one long result back-pressure hold.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
